/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* src/psc_pkg.sv */
// Package: constants, payload structs, controller states and command/status types.
package psc_pkg;
	localparam int MAX_VERTICES = 32;
	localparam int COORD_BITS   = 16;
	localparam int IDX_BITS     = 5;
	localparam int CNT_BITS     = 6;
	localparam int CW           = COORD_BITS;
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [IDX_BITS-1:0]  vertex_index;
		logic signed [CW-1:0] vertex_x;
		logic signed [CW-1:0] vertex_y;
		logic signed [CW-1:0] line_y;
	} cmd_t;

	typedef struct packed {
		logic signed [CW-1:0] crossing_x;
		logic [IDX_BITS-1:0]  upper_vertex;
		logic [IDX_BITS-1:0]  lower_vertex;
		logic [IDX_BITS-1:0]  crossing_rank;
		logic [CNT_BITS-1:0]  crossing_count;
		logic                 no_crossing;
		logic                 last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_TEST, ST_MUL, ST_DIV, ST_FIX, ST_INS, ST_EMIT_RD, ST_EMIT, ST_EMPTY
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic query_load; // capture query and clear
		logic rd;         // read current edge vertices
		logic mul;        // form product
		logic div_start;
		logic fix;        // apply sign, compute x
		logic ins_step;   // one insertion shift step
		logic emit_rd;
		logic emit;
		logic empty;
		logic next_edge;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic edges_done;
		logic crosses;
		logic div_done;
		logic ins_done;
		logic emit_done;
		logic none;
	} sts_t;
endpackage

/* src/polygon_scanline_crossings_core.sv */
// Top level: configuration register, controller and datapath.
// A load writes on accept. A query tests each edge; each crossing gets a product,
// a 34-step divide, a sign fix and insertion shifts; then results, one if empty.
// One transaction at a time; busy is high from query start to its last result.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (arst_n, async low) returns to idle and sets vertex_count to 3.
module polygon_scanline_crossings_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  psc_pkg::cmd_t                cmd,
	output logic                         busy,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [psc_pkg::CNT_BITS-1:0] cfg_data,
	output psc_pkg::result_t             result,
	output logic                         result_valid
);
	import psc_pkg::*;
	`include "assert_macros.svh"

	logic [CNT_BITS-1:0] vcount_q;
	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= CNT_BITS'(3);
		else if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
	end

	psc_ctrl u_ctrl (.clk, .arst_n, .start, .func(cmd.func), .sts, .ctl, .busy);

	psc_dp u_dp (
		.clk, .arst_n, .start, .busy, .cmd, .vcount(vcount_q), .ctl, .sts,
		.result, .result_valid);

	`CHK_IMPL(a_res_busy, clk, arst_n, result_valid, busy, "result outside query")
	`CHK_NEXT(a_last_idle, clk, arst_n, result_valid && result.last, !busy,
		"busy after last result")
	`CHK_IMPL(a_empty_last, clk, arst_n, result_valid && result.no_crossing, result.last,
		"empty result not last")
endmodule

/* src/psc_ram.sv */
// Generic single-write RAM with registered read.
module psc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/psc_ctrl.sv */
// Controller state machine for queries: edge walk, division, insertion and emission.
module psc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           func,
	input  psc_pkg::sts_t  sts,
	output psc_pkg::ctl_t  ctl,
	output logic           busy
);
	import psc_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (start && func == FUNC_QUERY) state_d = ST_RD;
			ST_RD:      state_d = ST_TEST;
			ST_TEST: begin
				if (sts.crosses) state_d = ST_MUL;
				else if (sts.edges_done) state_d = sts.none ? ST_EMPTY : ST_EMIT_RD;
				else state_d = ST_RD;
			end
			ST_MUL:     state_d = ST_DIV;
			ST_DIV:     if (sts.div_done) state_d = ST_FIX;
			ST_FIX:     state_d = ST_INS;
			ST_INS: begin
				if (sts.ins_done) begin
					state_d = sts.edges_done ? ST_EMIT_RD : ST_RD;
				end
			end
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT:    state_d = sts.emit_done ? ST_IDLE : ST_EMIT_RD;
			ST_EMPTY:   state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:    ctl.query_load = start && func == FUNC_QUERY;
			ST_RD:      ctl.rd = 1'b1;
			ST_TEST:    ctl.next_edge = !sts.crosses;
			ST_MUL: begin
				ctl.mul = 1'b1;
				ctl.div_start = 1'b1;
			end
			ST_FIX:     ctl.fix = 1'b1;
			ST_INS: begin
				ctl.ins_step = 1'b1;
				ctl.next_edge = sts.ins_done;
			end
			ST_EMIT_RD: ctl.emit_rd = 1'b1;
			ST_EMIT:    ctl.emit = 1'b1;
			ST_EMPTY:   ctl.empty = 1'b1;
			default:    ctl = '0;
		endcase
	end
endmodule

/* src/psc_dp.sv */
// Datapath: vertex stores, edge test, serial divider, sorted crossing list.
module psc_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  psc_pkg::cmd_t             cmd,
	input  logic [psc_pkg::CNT_BITS-1:0] vcount,
	input  psc_pkg::ctl_t             ctl,
	output psc_pkg::sts_t             sts,
	output psc_pkg::result_t          result,
	output logic                      result_valid
);
	import psc_pkg::*;
	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int DW  = COORD_BITS + 1;          // difference magnitude
	localparam int PW  = 2 * DW;                  // product magnitude
	localparam int QC  = $clog2(PW + 1);
	localparam int LD  = 32;                      // sorted list depth
	localparam int LW  = $clog2(LD);
	localparam int EW  = COORD_BITS + 2 * IDX_BITS;

	// vertex stores
	logic [AW-1:0] edge_q, prev_q;
	logic [COORD_BITS-1:0] rx_i, ry_i, rx_j, ry_j;
	logic we;
	logic [NW-1:0] n_q;
	logic [AW-1:0] widx;

	assign widx = AW'(cmd.vertex_index);
	assign we = start && !busy && cmd.func == FUNC_LOAD &&
		({{(32-IDX_BITS){1'b0}}, cmd.vertex_index} < MAX_VERTICES);

	psc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_xi (
		.clk, .we, .waddr(widx), .wdata(COORD_BITS'(cmd.vertex_x)), .raddr(edge_q), .rdata(rx_i));
	psc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_yi (
		.clk, .we, .waddr(widx), .wdata(COORD_BITS'(cmd.vertex_y)), .raddr(edge_q), .rdata(ry_i));
	psc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_xj (
		.clk, .we, .waddr(widx), .wdata(COORD_BITS'(cmd.vertex_x)), .raddr(prev_q), .rdata(rx_j));
	psc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_yj (
		.clk, .we, .waddr(widx), .wdata(COORD_BITS'(cmd.vertex_y)), .raddr(prev_q), .rdata(ry_j));

	// saturated vertex count
	logic [NW-1:0] n_sat;
	always_comb begin
		if (vcount < 6'd3) n_sat = NW'(3);
		else if ({26'd0, vcount} > MAX_VERTICES) n_sat = NW'(MAX_VERTICES);
		else n_sat = NW'(vcount);
	end

	// edge walk
	logic signed [COORD_BITS-1:0] ly_q;
	logic signed [COORD_BITS:0] xi, yi, xj, yj, lyx;
	logic a_up, b_up;
	assign xi = {rx_i[COORD_BITS-1], rx_i};
	assign yi = {ry_i[COORD_BITS-1], ry_i};
	assign xj = {rx_j[COORD_BITS-1], rx_j};
	assign yj = {ry_j[COORD_BITS-1], ry_j};
	assign lyx = {ly_q[COORD_BITS-1], ly_q};
	assign a_up = (yi > lyx) && (yj < lyx);
	assign b_up = (yi < lyx) && (yj > lyx);

	always_ff @(posedge clk) begin
		if (ctl.query_load) begin
			ly_q   <= COORD_BITS'(cmd.line_y);
			n_q    <= n_sat;
			edge_q <= '0;
			prev_q <= AW'(n_sat - NW'(1));
		end else if (ctl.next_edge) begin
			prev_q <= edge_q;
			edge_q <= edge_q + AW'(1);
		end
	end
	logic last_edge;
	assign last_edge = (edge_q == AW'(n_q - NW'(1)));

	// per-crossing operands
	logic [DW-1:0] mdx_q, mdy_q, mden_q;
	logic neg_q, upa_q;
	logic signed [COORD_BITS:0] xi_q;
	logic [AW-1:0] ei_q, ej_q;
	logic signed [COORD_BITS+1:0] dx, dy, den;
	assign dx  = (COORD_BITS+2)'(xj) - (COORD_BITS+2)'(xi);
	assign dy  = (COORD_BITS+2)'(lyx) - (COORD_BITS+2)'(yi);
	assign den = (COORD_BITS+2)'(yj) - (COORD_BITS+2)'(yi);

	logic test_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) test_q <= 1'b0;
		else test_q <= ctl.rd;
	end

	always_ff @(posedge clk) begin
		if (test_q) begin
			mdx_q  <= DW'(dx[COORD_BITS+1] ? -dx : dx);
			mdy_q  <= DW'(dy[COORD_BITS+1] ? -dy : dy);
			mden_q <= DW'(den[COORD_BITS+1] ? -den : den);
			neg_q  <= (dx[COORD_BITS+1] ^ dy[COORD_BITS+1]) ^ den[COORD_BITS+1];
			xi_q   <= xi;
			upa_q  <= a_up;
			ei_q   <= edge_q;
			ej_q   <= prev_q;
		end
	end

	// product then restoring division, one quotient bit per cycle
	logic [PW-1:0] prod_q, quo_q;
	logic [DW:0] rem_q;
	logic [QC-1:0] dcnt_q;
	logic div_busy_q;
	logic [DW:0] rem_sh;
	assign rem_sh = {rem_q[DW-1:0], prod_q[PW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dcnt_q <= '0;
		end else if (ctl.div_start) begin
			div_busy_q <= 1'b1;
			dcnt_q <= QC'(PW);
		end else if (div_busy_q) begin
			dcnt_q <= dcnt_q - QC'(1);
			if (dcnt_q == QC'(1)) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= PW'(mdx_q * mdy_q);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (div_busy_q) begin
			prod_q <= prod_q << 1;
			if (rem_sh >= {1'b0, mden_q}) begin
				rem_q <= rem_sh - {1'b0, mden_q};
				quo_q <= {quo_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[PW-2:0], 1'b0};
			end
		end
	end
	logic div_done;
	assign div_done = !div_busy_q && !ctl.div_start;

	// crossing x; quotient stays below the coordinate span
	logic signed [COORD_BITS:0] x_new_q;
	logic signed [COORD_BITS:0] qs;
	assign qs = (COORD_BITS+1)'(quo_q);
	always_ff @(posedge clk) begin
		if (ctl.fix) x_new_q <= neg_q ? xi_q - qs : xi_q + qs;
	end

	// sorted list, stable insertion one shift per cycle
	logic [EW-1:0] lst_q [LD];
	logic [CNT_BITS:0] cnt_q;
	logic [LW:0] pos_q;
	logic [EW-1:0] ent_new;
	logic signed [COORD_BITS-1:0] prev_x;
	logic [IDX_BITS-1:0] up_v, dn_v;
	assign up_v = IDX_BITS'(upa_q ? ei_q : ej_q);
	assign dn_v = IDX_BITS'(upa_q ? ej_q : ei_q);
	assign ent_new = {COORD_BITS'(x_new_q), up_v, dn_v};
	assign prev_x = lst_q[LW'(pos_q - (LW+1)'(1))][EW-1 -: COORD_BITS];
	logic shift_cond;
	assign shift_cond = (pos_q != '0) && (prev_x > COORD_BITS'(x_new_q));
	logic ins_done;
	assign ins_done = !shift_cond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
		end else if (ctl.query_load) begin
			cnt_q <= '0;
			pos_q <= '0;
		end else if (ctl.fix) begin
			pos_q <= (LW+1)'(cnt_q);
		end else if (ctl.ins_step) begin
			if (shift_cond) begin
				pos_q <= pos_q - (LW+1)'(1);
			end else begin
				cnt_q <= cnt_q + (CNT_BITS+1)'(1);
				// list complete after the last edge: rewind for emission
				if (sts.edges_done) pos_q <= '0;
			end
		end else if (ctl.emit) begin
			pos_q <= pos_q + (LW+1)'(1);
		end else if (ctl.next_edge && sts.edges_done) begin
			pos_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_step) begin
			if (shift_cond) lst_q[LW'(pos_q)] <= lst_q[LW'(pos_q - (LW+1)'(1))];
			else lst_q[LW'(pos_q)] <= ent_new;
		end
	end

	// emission
	logic [EW-1:0] ent_rd_q;
	always_ff @(posedge clk) begin
		if (ctl.emit_rd) ent_rd_q <= lst_q[LW'(pos_q)];
	end
	logic [LW:0] emit_n;
	assign emit_n = (LW+1)'(cnt_q);
	always_comb begin
		result = '0;
		result_valid = ctl.emit || ctl.empty;
		if (ctl.emit) begin
			result.crossing_x     = CW'(signed'(ent_rd_q[EW-1 -: COORD_BITS]));
			result.upper_vertex   = ent_rd_q[2*IDX_BITS-1 -: IDX_BITS];
			result.lower_vertex   = ent_rd_q[IDX_BITS-1:0];
			result.crossing_rank  = IDX_BITS'(pos_q);
			result.crossing_count = CNT_BITS'(cnt_q);
			result.last           = (pos_q + (LW+1)'(1) == emit_n);
		end else if (ctl.empty) begin
			result.no_crossing = 1'b1;
			result.last        = 1'b1;
		end
	end

	assign sts.edges_done = last_edge;
	assign sts.crosses    = test_q && (a_up || b_up);
	assign sts.div_done   = div_done;
	assign sts.ins_done   = ins_done;
	assign sts.emit_done  = (pos_q + (LW+1)'(1) == emit_n);
	assign sts.none       = (cnt_q == '0);
endmodule

/* bench/tb_top.sv */
// Testbench for the polygon scanline crossings core: scoreboard, drivers and checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import psc_pkg::*;

	localparam int NVERT      = 32;
	localparam int IDLE_LIMIT = 50000;

	// Expected-result tracker: own copy of the vertex store and the count register
	class crossing_board;
		logic signed [CW-1:0] vx [NVERT];
		logic signed [CW-1:0] vy [NVERT];
		logic [CNT_BITS-1:0]  vertex_count;
		result_t              pending [$];
		int                   errors;
		int                   matched;

		function new();
			vertex_count = CNT_BITS'(3);
			errors = 0;
			matched = 0;
		endfunction

		// Compute the results of one accepted transaction
		function void note_cmd(cmd_t c);
			longint cx [NVERT];
			int     up [NVERT];
			int     dn [NVERT];
			int     cnt, n, i, j, p;
			longint ly, xi, xj, yi, yj, x;
			bit     above, below;
			result_t r;
			cnt = 0;
			if (c.func == FUNC_LOAD) begin
				vx[c.vertex_index] = c.vertex_x;
				vy[c.vertex_index] = c.vertex_y;
				return;
			end
			n = vertex_count;
			if (n < 3) n = 3;
			if (n > NVERT) n = NVERT;
			ly = c.line_y;
			for (int k = 0; k < n; k++) begin
				i = k;
				j = (k == 0) ? n - 1 : k - 1;
				xi = vx[i]; xj = vx[j]; yi = vy[i]; yj = vy[j];
				above = (yi > ly) && (yj < ly);
				below = (yi < ly) && (yj > ly);
				if (above || below) begin
					// division truncates toward zero
					x = xi + ((xj - xi) * (ly - yi)) / (yj - yi);
					p = cnt;
					while (p > 0 && cx[p-1] > x) begin
						cx[p] = cx[p-1]; up[p] = up[p-1]; dn[p] = dn[p-1];
						p--;
					end
					cx[p] = x;
					up[p] = above ? i : j;
					dn[p] = above ? j : i;
					cnt++;
				end
			end
			if (cnt == 0) begin
				r = '0;
				r.no_crossing = 1'b1;
				r.last = 1'b1;
				pending.push_back(r);
				return;
			end
			for (int k = 0; k < cnt && k < 32; k++) begin
				r.crossing_x     = cx[k][CW-1:0];
				r.upper_vertex   = up[k][IDX_BITS-1:0];
				r.lower_vertex   = dn[k][IDX_BITS-1:0];
				r.crossing_rank  = k[IDX_BITS-1:0];
				r.crossing_count = (cnt > 63) ? 6'd63 : cnt[CNT_BITS-1:0];
				r.no_crossing    = 1'b0;
				r.last           = (k == cnt - 1 || k == 31);
				pending.push_back(r);
			end
		endfunction

		function void cmp(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compare one strobed result against the oldest expectation
		function void check_result(result_t r);
			result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: crossing_x %0d last %0b", r.crossing_x, r.last);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("crossing_x", e.crossing_x, r.crossing_x);
			cmp("upper_vertex", e.upper_vertex, r.upper_vertex);
			cmp("lower_vertex", e.lower_vertex, r.lower_vertex);
			cmp("crossing_rank", e.crossing_rank, r.crossing_rank);
			cmp("crossing_count", e.crossing_count, r.crossing_count);
			cmp("no_crossing", e.no_crossing, r.no_crossing);
			cmp("last", e.last, r.last);
			matched++;
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	cmd_t                cmd = '0;
	logic                busy;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CNT_BITS-1:0] cfg_data = '0;
	result_t             result;
	logic                result_valid;

	crossing_board board = new();
	int idle_cycles = 0;
	int n_loads = 0, n_queries = 0, n_empty = 0, n_cfg = 0;

	polygon_scanline_crossings_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result(result), .result_valid(result_valid)
	);

	always #5 clk = ~clk;

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (result.no_crossing) n_empty++;
			board.check_result(result);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results pending", board.pending.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Present one command and hold it until accepted; start stays high afterward
	task automatic send_cmd(cmd_t c);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0 && (gap != 1 || $urandom_range(0, 1))) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_cmd(c);
		if (c.func == FUNC_LOAD) n_loads++; else n_queries++;
	endtask

	task automatic load_vertex(int idx, int x, int y);
		cmd_t c;
		c = '0;
		c.func = FUNC_LOAD;
		c.vertex_index = IDX_BITS'(idx);
		c.vertex_x = CW'(x);
		c.vertex_y = CW'(y);
		send_cmd(c);
	endtask

	task automatic query_line(int y);
		cmd_t c;
		c.func = FUNC_QUERY;
		c.vertex_index = IDX_BITS'($urandom);
		c.vertex_x = CW'($urandom);
		c.vertex_y = CW'($urandom);
		c.line_y = CW'(y);
		send_cmd(c);
	endtask

	// Lower start and wait until every expected result is in and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_BITS-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.vertex_count = v;
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	// Random coordinate: narrow range for ties and vertices on the line, else full range
	function automatic int rand_coord(bit narrow);
		if (narrow) return $urandom_range(0, 8) * 64 - 256;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	initial begin
		logic [CNT_BITS-1:0] settings [10];
		bit narrow;
		settings = '{6'd32, 6'd0, 6'd63, 6'd3, 6'd7, 6'd33, 6'd2, 6'd17, 6'd31, 6'd32};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zigzag polygon with coordinate extremes
		for (int k = 0; k < NVERT; k++)
			load_vertex(k, (k == 0) ? -32768 : (k == 31) ? 32767 : k * 1000 - 16000,
				(k == 0) ? -32768 : (k == 31) ? 32767 : ((k % 2) ? 20000 : -20000));
		write_count(6'd32);
		query_line(0);           // many crossings
		query_line(20000);       // odd vertices on the line
		query_line(-32768);      // extreme low: vertex on the line, no crossing
		query_line(32767);       // extreme high
		query_line(30000);       // crossings only near the last vertex
		load_vertex(5, 0, 0);
		query_line(0);           // vertex exactly on the line
		query_line(-1);

		// Random phases through several register settings
		foreach (settings[s]) begin
			write_count(settings[s]);
			narrow = (s % 3 == 1);
			for (int t = 0; t < 50; t++) begin
				if ($urandom_range(0, 9) < 4)
					load_vertex($urandom_range(0, 31), rand_coord(narrow), rand_coord(narrow));
				else if ($urandom_range(0, 3) == 0)
					query_line(int'($urandom_range(0, 65535)) - 32768);
				else
					query_line(rand_coord(narrow));
				if (t == 25) drain();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (board.pending.size() != 0) begin
			$error("%0d expected results never arrived", board.pending.size());
			board.errors++;
		end
		$display("Covered %0d loads and %0d queries (%0d empty), %0d results checked,",
			n_loads, n_queries, n_empty, board.matched);
		$display("over %0d vertex count settings including 0, 2, 33 and 63.", n_cfg);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

/* polygon_scanline_crossings_core.f */
+incdir+src
src/psc_pkg.sv
src/psc_ram.sv
src/psc_ctrl.sv
src/psc_dp.sv
src/polygon_scanline_crossings_core.sv
bench/tb_top.sv
